@@ sv/jss_pkg.sv @@
// ----------------------------------------------------------------------------
// jss_pkg
// Shared constants and types for the Jacobi stencil sweep block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jss_pkg;

    localparam int MAX_GRID  = 1024;
    localparam int IDX_W     = $clog2(MAX_GRID);
    localparam int CNT_W     = IDX_W + 1;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = DATA_W + 2;
    localparam int GS_W      = 11;
    localparam int BANKS     = 3;
    localparam int BANK_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONVERGE_LIMIT = 1'd1;

    localparam logic [CNT_W-1:0]  GRID_SIZE_RESET = CNT_W'(MAX_GRID);
    localparam logic [CNT_W-1:0]  GRID_SIZE_MIN   = CNT_W'(3);
    localparam logic [DATA_W-1:0] LIMIT_RESET     = 32'd1;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
        logic first;
    } stage_flags_t;

endpackage

`default_nettype wire

@@ sv/jss_cell_if.sv @@
// ----------------------------------------------------------------------------
// jss_cell_if
// Input stream channel: one old grid value per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jss_cell_if;

    logic                        valid;
    logic                        ready;
    logic [jss_pkg::DATA_W-1:0]  cell_value;
    logic                        grid_start;

    modport source (output valid, output cell_value, output grid_start, input ready);
    modport sink   (input valid, input cell_value, input grid_start, output ready);

endinterface

`default_nettype wire

@@ sv/jss_result_if.sv @@
// ----------------------------------------------------------------------------
// jss_result_if
// Result stream channel: one updated grid value per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jss_result_if;

    logic                        valid;
    logic                        ready;
    logic [jss_pkg::DATA_W-1:0]  new_value;
    logic [jss_pkg::DATA_W-1:0]  max_change;
    logic                        grid_end;
    logic                        converged;

    modport source (output valid, output new_value, output max_change,
                    output grid_end, output converged, input ready);
    modport sink   (input valid, input new_value, input max_change,
                    input grid_end, input converged, output ready);

endinterface

`default_nettype wire

@@ sv/jss_ram.sv @@
// ----------------------------------------------------------------------------
// jss_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr_b,
    output logic      [WIDTH-1:0]           rdata_a,
    output logic      [WIDTH-1:0]           rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

@@ sv/jacobi_stencil_sweep.sv @@
// ----------------------------------------------------------------------------
// jacobi_stencil_sweep
// One Jacobi sweep, 5-point stencil, over a raster-order stream of Q16.16
// cells, with a three-row line store and a running maximum change.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake       Payload
//  cells     in   valid/ready     cell_value[31:0], grid_start
//  results   out  valid/ready     new_value[31:0], max_change[31:0],
//                                 grid_end, converged
//  cfg       in   cfg_wr_en       cfg_index[0], cfg_wr_data[31:0]
//
//  One cell per cycle while results are accepted; each result passes through
//  the line store read register, stencil adder, change stage and output register.
//  Rows 0 and 1 and the first row after a restart produce no result.
//  Reset clears counters, running maximum and pipeline valids; the line store
//  is not cleared. Stalls propagate stage by stage; empty stages keep
//  accepting while a result waits on the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jacobi_stencil_sweep (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [jss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [jss_pkg::DATA_W-1:0]        cfg_wr_data,
    jss_cell_if.sink                               cells,
    jss_result_if.source                           results
);

    // configuration
    logic [jss_pkg::CNT_W-1:0]  n_reg;
    logic [jss_pkg::DATA_W-1:0] limit_reg;
    logic [jss_pkg::GS_W-1:0]   gs_wr;
    logic [jss_pkg::CNT_W-1:0]  n_next;

    // position counters
    logic [jss_pkg::IDX_W-1:0]  row_reg, col_reg;
    logic [jss_pkg::BANK_W-1:0] bank_reg;
    logic [jss_pkg::IDX_W-1:0]  row_next, col_next;
    logic [jss_pkg::BANK_W-1:0] bank_next;

    logic                       in_xfer, restart, col_wrap, row_wrap;
    logic [jss_pkg::IDX_W-1:0]  r_cur, c_cur, c_ahead;
    logic [jss_pkg::CNT_W-1:0]  r_ext, c_ext;
    logic [jss_pkg::BANK_W-1:0] b_cur, bm1_cur, bm2_cur;
    jss_pkg::stage_flags_t      flags_cur;

    // line store
    logic [jss_pkg::DATA_W-1:0] rd_a [jss_pkg::BANKS];
    logic [jss_pkg::DATA_W-1:0] rd_b [jss_pkg::BANKS];

    // pipeline
    logic                       v1_reg, v2_reg, v3_reg, ov_reg;
    logic                       s1_free, s2_free, s3_free, s3_go, out_en;
    jss_pkg::stage_flags_t      f1_reg, f2_reg, f3_reg;
    logic [jss_pkg::DATA_W-1:0] val1_reg;
    logic [jss_pkg::BANK_W-1:0] bm1_reg, bm2_reg;
    logic [jss_pkg::DATA_W-1:0] lft_reg;

    logic [jss_pkg::DATA_W-1:0] up_s2, old_s2, right_s2, newv_s2;
    logic [jss_pkg::SUM_W-1:0]  sum_s2;
    logic [jss_pkg::DATA_W-1:0] newv2_reg, oldv2_reg;

    logic [jss_pkg::DATA_W-1:0] diff_s3;
    logic [jss_pkg::DATA_W-1:0] newv3_reg, diff3_reg;

    logic [jss_pkg::DATA_W-1:0] max_reg, max_next;
    logic                       grows, conv_s4;
    logic [jss_pkg::DATA_W-1:0] nv_o_reg, mx_o_reg;
    logic                       ge_o_reg, cv_o_reg;

    // ---------------------------------------------------------------- config
    assign gs_wr = cfg_wr_data[jss_pkg::GS_W-1:0];

    always_comb
    begin
        if (jss_pkg::CNT_W'(gs_wr) < jss_pkg::GRID_SIZE_MIN
            && jss_pkg::GS_W <= jss_pkg::CNT_W)
        begin
            n_next = jss_pkg::GRID_SIZE_MIN;
        end
        else if (int'(gs_wr) < 3)
        begin
            n_next = jss_pkg::GRID_SIZE_MIN;
        end
        else if (int'(gs_wr) > jss_pkg::MAX_GRID)
        begin
            n_next = jss_pkg::GRID_SIZE_RESET;
        end
        else
        begin
            n_next = jss_pkg::CNT_W'(gs_wr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= jss_pkg::GRID_SIZE_RESET;
            limit_reg <= jss_pkg::LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                jss_pkg::REG_GRID_SIZE:      n_reg     <= n_next;
                jss_pkg::REG_CONVERGE_LIMIT: limit_reg <= cfg_wr_data;
                default:                     ;
            endcase
        end
    end

    // -------------------------------------------------------------- counters
    assign in_xfer = cells.valid && s1_free;
    assign restart = cells.grid_start
                     || {1'b0, row_reg} >= n_reg
                     || {1'b0, col_reg} >= n_reg;

    assign r_cur   = restart ? '0 : row_reg;
    assign c_cur   = restart ? '0 : col_reg;
    assign b_cur   = restart ? '0 : bank_reg;
    assign r_ext   = {1'b0, r_cur};
    assign c_ext   = {1'b0, c_cur};
    assign c_ahead = c_cur + 1'b1;

    assign col_wrap = (c_ext + 1'b1) >= n_reg;
    assign row_wrap = (r_ext + 1'b1) >= n_reg;

    assign flags_cur.emit     = r_ext >= jss_pkg::CNT_W'(2);
    assign flags_cur.interior = flags_cur.emit && (c_cur != '0) && !col_wrap;
    assign flags_cur.last     = row_wrap && col_wrap;
    assign flags_cur.first    = (r_cur == '0) && (c_cur == '0);

    always_comb
    begin
        unique case (b_cur)
            2'd0:    begin bm1_cur = 2'd2; bm2_cur = 2'd1; end
            2'd1:    begin bm1_cur = 2'd0; bm2_cur = 2'd2; end
            2'd2:    begin bm1_cur = 2'd1; bm2_cur = 2'd0; end
            default: begin bm1_cur = 2'd0; bm2_cur = 2'd0; end
        endcase
    end

    always_comb
    begin
        row_next  = r_cur;
        col_next  = c_cur + 1'b1;
        bank_next = b_cur;
        if (col_wrap)
        begin
            col_next = '0;
            if (row_wrap)
            begin
                row_next  = '0;
                bank_next = '0;
            end
            else
            begin
                row_next  = r_cur + 1'b1;
                bank_next = (b_cur == 2'd2) ? 2'd0 : b_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            bank_reg <= '0;
        end
        else if (in_xfer)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            bank_reg <= bank_next;
        end
    end

    // ------------------------------------------------------------ line store
    for (genvar k = 0; k < jss_pkg::BANKS; k++)
    begin : g_bank
        jss_ram #(
            .WIDTH (jss_pkg::DATA_W),
            .DEPTH (jss_pkg::MAX_GRID)
        ) u_row (
            .clk     (clk),
            .we      (in_xfer && (b_cur == jss_pkg::BANK_W'(k))),
            .waddr   (c_cur),
            .wdata   (cells.cell_value),
            .re      (in_xfer),
            .raddr_a (c_cur),
            .raddr_b (c_ahead),
            .rdata_a (rd_a[k]),
            .rdata_b (rd_b[k])
        );
    end

    // ------------------------------------------------------------ pipe control
    assign out_en  = !ov_reg || results.ready;
    assign s3_go   = v3_reg && (!f3_reg.emit || out_en);
    assign s3_free = !v3_reg || s3_go;
    assign s2_free = !v2_reg || s3_free;
    assign s1_free = !v1_reg || s2_free;

    assign cells.ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                v1_reg <= cells.valid;
            end
            if (s2_free)
            begin
                v2_reg <= v1_reg;
            end
            if (s3_free)
            begin
                v3_reg <= v2_reg;
            end
            if (out_en)
            begin
                ov_reg <= s3_go && f3_reg.emit;
            end
        end
    end

    // stage 1: item metadata beside the read register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            val1_reg <= cells.cell_value;
            f1_reg   <= flags_cur;
            bm1_reg  <= bm1_cur;
            bm2_reg  <= bm2_cur;
        end
    end

    // stage 2: stencil sum
    assign up_s2    = rd_a[bm2_reg];
    assign old_s2   = rd_a[bm1_reg];
    assign right_s2 = rd_b[bm1_reg];
    assign sum_s2   = jss_pkg::SUM_W'(up_s2) + jss_pkg::SUM_W'(val1_reg)
                    + jss_pkg::SUM_W'(lft_reg) + jss_pkg::SUM_W'(right_s2);
    assign newv_s2  = f1_reg.interior ? sum_s2[jss_pkg::SUM_W-1:2] : old_s2;

    always_ff @(posedge clk)
    begin
        if (v1_reg && s2_free)
        begin
            lft_reg   <= old_s2;
            newv2_reg <= newv_s2;
            oldv2_reg <= old_s2;
            f2_reg    <= f1_reg;
        end
    end

    // stage 3: absolute change
    always_comb
    begin
        if (!f2_reg.interior)
        begin
            diff_s3 = '0;
        end
        else if (newv2_reg > oldv2_reg)
        begin
            diff_s3 = newv2_reg - oldv2_reg;
        end
        else
        begin
            diff_s3 = oldv2_reg - newv2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && s3_free)
        begin
            newv3_reg <= newv2_reg;
            diff3_reg <= diff_s3;
            f3_reg    <= f2_reg;
        end
    end

    // stage 4: running maximum and output register
    assign grows    = diff3_reg > max_reg;
    assign max_next = grows ? diff3_reg : max_reg;
    assign conv_s4  = f3_reg.last
                      && (grows ? (diff3_reg < limit_reg) : (max_reg < limit_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
        end
        else if (s3_go)
        begin
            if (f3_reg.first)
            begin
                max_reg <= '0;
            end
            else if (f3_reg.emit)
            begin
                max_reg <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s3_go && f3_reg.emit)
        begin
            nv_o_reg <= newv3_reg;
            mx_o_reg <= max_next;
            ge_o_reg <= f3_reg.last;
            cv_o_reg <= conv_s4;
        end
    end

    assign results.valid      = ov_reg;
    assign results.new_value  = nv_o_reg;
    assign results.max_change = mx_o_reg;
    assign results.grid_end   = ge_o_reg;
    assign results.converged  = cv_o_reg;

    // ------------------------------------------------------------ assertions
    a_conv_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.converged |-> results.grid_end)
        else $error("converged without grid_end");

    a_conv_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.converged |-> results.max_change < limit_reg)
        else $error("converged with max_change at or above limit");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !cells.ready |-> v1_reg && v2_reg && v3_reg && ov_reg)
        else $error("input stalled with an empty pipeline stage");

endmodule

`default_nettype wire
